// File: design/dna_pkg.sv
// ----------------------------------------------------------------------------
// dna_pkg: shared types, constants and helpers for the dual number ALU
// Fixed-point format, opcodes, divider cell word types, saturation helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dna_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int DVD_W     = PROD_W + FRAC_BITS;  // dividend bits, one per cell
    localparam int NUM_CELLS = DVD_W;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic              ov;
        logic [DATA_W-1:0] val;
    } sat_t;

    // one divider lane: partial remainder, dividend/quotient shift word, divisor
    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [DVD_W-1:0]  dq;
        logic [PROD_W-1:0] den;
    } lane_t;

    // control and finished non-divide results riding along the cell row
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              dz;
        logic              neg_r;
        logic              neg_d;
        logic              alt_ov;
        logic [DATA_W-1:0] alt_real;
        logic [DATA_W-1:0] alt_dual;
    } side_t;

    // clamp a wide signed value to DATA_W bits
    function automatic sat_t sat_wide(input logic signed [PROD_W+1:0] x);
        sat_t r;
        r.ov  = 1'b0;
        r.val = x[DATA_W-1:0];
        if (x > $signed({{(PROD_W-DATA_W+3){1'b0}}, SAT_MAX[DATA_W-2:0]}))
        begin
            r.ov  = 1'b1;
            r.val = SAT_MAX;
        end
        else if (x < -$signed({{(PROD_W-DATA_W+2){1'b0}}, 1'b1,
                               {(DATA_W-1){1'b0}}}))
        begin
            r.ov  = 1'b1;
            r.val = SAT_MIN;
        end
        return r;
    endfunction

    // apply sign to a quotient magnitude and clamp
    function automatic sat_t sat_mag(input logic neg, input logic [DVD_W-1:0] q);
        sat_t r;
        logic [DVD_W-1:0] lim;
        lim   = {{(DVD_W-DATA_W){1'b0}}, SAT_MAX};
        r.ov  = 1'b0;
        r.val = neg ? (~q[DATA_W-1:0] + 1'b1) : q[DATA_W-1:0];
        if (neg && (q > lim + 1'b1))
        begin
            r.ov  = 1'b1;
            r.val = SAT_MIN;
        end
        else if (!neg && (q > lim))
        begin
            r.ov  = 1'b1;
            r.val = SAT_MAX;
        end
        return r;
    endfunction

endpackage

// File: design/dual_number_alu_unit.sv
// Pipeline: 2 front stages, 80 divider cells and 1 output register lie between
//   input accept and result valid; every mode takes the same path.
// Throughput: one word per cycle; the divider is a row of cells, one quotient
//   bit each, so a new word enters every cycle unless the output stalls.
// Reset: rst_n clears all valid bits; the pipeline comes up empty.
// ----------------------------------------------------------------------------
// dual_number_alu_unit: dual number add/sub/mul/div, signed fixed point
// Saturating results with overflow and divide-by-zero flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_number_alu_unit
    import dna_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // s_tdata: a_real, a_dual, b_real, b_dual (low to high)
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [4*DATA_W-1:0]   s_tdata,
    // s_tuser: mode
    input  logic [1:0]            s_tuser,
    // m_tdata: res_real, res_dual (low to high)
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*DATA_W-1:0]   m_tdata,
    // m_tuser: overflow, div_by_zero (low to high)
    output logic [1:0]            m_tuser
);

    // whole pipe moves together; it holds only while the output word waits
    logic en;

    side_t side_c [0:NUM_CELLS];
    lane_t lr_c   [0:NUM_CELLS];
    lane_t ld_c   [0:NUM_CELLS];

    logic                  out_valid_reg;
    logic [2*DATA_W-1:0]   out_data_reg, out_data_next;
    logic [1:0]            out_user_reg, out_user_next;

    sat_t  q_r, q_d;
    side_t tail;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    dna_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .mode     (s_tuser),
        .a_real   (s_tdata[DATA_W-1:0]),
        .a_dual   (s_tdata[2*DATA_W-1:DATA_W]),
        .b_real   (s_tdata[3*DATA_W-1:2*DATA_W]),
        .b_dual   (s_tdata[4*DATA_W-1:3*DATA_W]),
        .side     (side_c[0]),
        .lane_r   (lr_c[0]),
        .lane_d   (ld_c[0])
    );

    // one quotient bit per cell, MSB first
    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++)
        begin : g_cell
            dna_div_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .side_in  (side_c[g]),
                .lr_in    (lr_c[g]),
                .ld_in    (ld_c[g]),
                .side_out (side_c[g+1]),
                .lr_out   (lr_c[g+1]),
                .ld_out   (ld_c[g+1])
            );
        end
    endgenerate

    // final sign, clamp and mode select
    always_comb
    begin
        tail = side_c[NUM_CELLS];
        q_r  = sat_mag(tail.neg_r, lr_c[NUM_CELLS].dq);
        q_d  = sat_mag(tail.neg_d, ld_c[NUM_CELLS].dq);
        if (!tail.is_div)
        begin
            out_data_next = {tail.alt_dual, tail.alt_real};
            out_user_next = {1'b0, tail.alt_ov};
        end
        else if (tail.dz)
        begin
            // divide by zero: zero result, flag only
            out_data_next = '0;
            out_user_next = 2'b10;
        end
        else
        begin
            out_data_next = {q_d.val, q_r.val};
            out_user_next = {1'b0, q_r.ov | q_d.ov};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= tail.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// File: design/dna_front.sv
// ----------------------------------------------------------------------------
// dna_front: product stage and operand setup
// Stage 1 registers the four products, stage 2 forms add/sub/mul results
// and loads the two divider lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dna_front
    import dna_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [1:0]               mode,
    input  logic signed [DATA_W-1:0] a_real,
    input  logic signed [DATA_W-1:0] a_dual,
    input  logic signed [DATA_W-1:0] b_real,
    input  logic signed [DATA_W-1:0] b_dual,
    output side_t                    side,
    output lane_t                    lane_r,
    output lane_t                    lane_d
);

    logic                     v1_reg;
    logic [1:0]               mode1_reg;
    logic signed [DATA_W-1:0] ar_reg, ad_reg, br_reg, bd_reg;
    logic signed [PROD_W-1:0] prr_reg, prd_reg, pdr_reg, pbb_reg;

    side_t side_reg, side_next;
    lane_t lr_reg, lr_next, ld_reg, ld_next;

    logic signed [PROD_W+1:0] re_w, du_w;
    logic signed [PROD_W:0]   sum_p, num_d;
    logic [PROD_W-1:0]        mag_d;
    logic [DATA_W-1:0]        mag_ar, mag_br;
    sat_t                     s_re, s_du;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            side_reg <= '0;
        end
        else if (en)
        begin
            v1_reg   <= in_valid;
            side_reg <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode1_reg <= mode;
            ar_reg    <= a_real;
            ad_reg    <= a_dual;
            br_reg    <= b_real;
            bd_reg    <= b_dual;
            prr_reg   <= a_real * b_real;
            prd_reg   <= a_real * b_dual;
            pdr_reg   <= b_real * a_dual;
            pbb_reg   <= b_real * b_real;
            lr_reg    <= lr_next;
            ld_reg    <= ld_next;
        end
    end

    always_comb
    begin
        sum_p = {prd_reg[PROD_W-1], prd_reg} + {pdr_reg[PROD_W-1], pdr_reg};
        num_d = {pdr_reg[PROD_W-1], pdr_reg} - {prd_reg[PROD_W-1], prd_reg};
        case (mode1_reg)
            MODE_ADD:
            begin
                re_w = (PROD_W+2)'(ar_reg) + (PROD_W+2)'(br_reg);
                du_w = (PROD_W+2)'(ad_reg) + (PROD_W+2)'(bd_reg);
            end
            MODE_SUB:
            begin
                re_w = (PROD_W+2)'(ar_reg) - (PROD_W+2)'(br_reg);
                du_w = (PROD_W+2)'(ad_reg) - (PROD_W+2)'(bd_reg);
            end
            MODE_MUL:
            begin
                re_w = (PROD_W+2)'(prr_reg >>> FRAC_BITS);
                du_w = (PROD_W+2)'(sum_p >>> FRAC_BITS);
            end
            default:
            begin
                re_w = '0;
                du_w = '0;
            end
        endcase
        s_re = sat_wide(re_w);
        s_du = sat_wide(du_w);

        mag_ar = ar_reg[DATA_W-1] ? (~ar_reg + 1'b1) : ar_reg;
        mag_br = br_reg[DATA_W-1] ? (~br_reg + 1'b1) : br_reg;
        mag_d  = num_d[PROD_W] ? PROD_W'(-num_d) : num_d[PROD_W-1:0];

        side_next.valid    = v1_reg;
        side_next.is_div   = (mode1_reg == MODE_DIV);
        side_next.dz       = (br_reg == '0);
        side_next.neg_r    = ar_reg[DATA_W-1] ^ br_reg[DATA_W-1];
        side_next.neg_d    = num_d[PROD_W];
        side_next.alt_ov   = s_re.ov | s_du.ov;
        side_next.alt_real = s_re.val;
        side_next.alt_dual = s_du.val;

        lr_next.rem = '0;
        lr_next.dq  = {{(PROD_W-DATA_W){1'b0}}, mag_ar, {FRAC_BITS{1'b0}}};
        lr_next.den = {{(PROD_W-DATA_W){1'b0}}, mag_br};
        ld_next.rem = '0;
        ld_next.dq  = {mag_d, {FRAC_BITS{1'b0}}};
        ld_next.den = pbb_reg;
    end

    assign side   = side_reg;
    assign lane_r = lr_reg;
    assign lane_d = ld_reg;

endmodule

// File: design/dna_div_cell.sv
// ----------------------------------------------------------------------------
// dna_div_cell: one restoring-division step for both lanes
// Shifts one dividend bit into the remainder, trial-subtracts, shifts the
// quotient bit in; control rides along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dna_div_cell
    import dna_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  side_t side_in,
    input  lane_t lr_in,
    input  lane_t ld_in,
    output side_t side_out,
    output lane_t lr_out,
    output lane_t ld_out
);

    side_t side_reg;
    lane_t lr_reg, lr_next, ld_reg, ld_next;

    function automatic lane_t step(input lane_t x);
        lane_t           y;
        logic [PROD_W:0] trial;
        logic [PROD_W:0] diff;
        trial = {x.rem, x.dq[DVD_W-1]};
        diff  = trial - {1'b0, x.den};
        y.den = x.den;
        if (!diff[PROD_W])
        begin
            y.rem = diff[PROD_W-1:0];
            y.dq  = {x.dq[DVD_W-2:0], 1'b1};
        end
        else
        begin
            y.rem = trial[PROD_W-1:0];
            y.dq  = {x.dq[DVD_W-2:0], 1'b0};
        end
        return y;
    endfunction

    always_comb
    begin
        lr_next = step(lr_in);
        ld_next = step(ld_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else if (en)
            side_reg <= side_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lr_reg <= lr_next;
            ld_reg <= ld_next;
        end
    end

    assign side_out = side_reg;
    assign lr_out   = lr_reg;
    assign ld_out   = ld_reg;

endmodule

// File: design/dual_number_alu_unit_checker.sv
// ----------------------------------------------------------------------------
// dual_number_alu_unit_checker: port-level checks for the dual number ALU
// Watches the stream ports only; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_number_alu_unit_checker
    import dna_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [2*DATA_W-1:0] m_tdata,
    input logic [1:0]          m_tuser
);

    // a waiting output word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // input backpressure only comes from a stalled output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

    // divide by zero gives zero parts and no overflow
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
        else $error("divide by zero word not cleared");

    // overflow means at least one part sits at a limit
    a_ov: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            (m_tdata[DATA_W-1:0] == SAT_MAX) || (m_tdata[DATA_W-1:0] == SAT_MIN) ||
            (m_tdata[2*DATA_W-1:DATA_W] == SAT_MAX) ||
            (m_tdata[2*DATA_W-1:DATA_W] == SAT_MIN))
        else $error("overflow flag without saturated part");

endmodule

bind dual_number_alu_unit dual_number_alu_unit_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
